>>> rtl/lbc_pkg.sv
// Package for the line-break classifier: class codes, break kinds, state type.
// No dependencies.
package lbc_pkg;
   localparam logic [5:0] C_BK = 6'd0, C_CR = 6'd1, C_LF = 6'd2, C_CM = 6'd3, C_NL = 6'd4,
      C_SG = 6'd5, C_WJ = 6'd6, C_ZW = 6'd7, C_GL = 6'd8, C_SP = 6'd9, C_ZWJ = 6'd10,
      C_B2 = 6'd11, C_BA = 6'd12, C_BB = 6'd13, C_HY = 6'd14, C_CB = 6'd15, C_CL = 6'd16,
      C_CP = 6'd17, C_EX = 6'd18, C_IN = 6'd19, C_NS = 6'd20, C_OP = 6'd21, C_QU = 6'd22,
      C_IS = 6'd23, C_NU = 6'd24, C_PO = 6'd25, C_PR = 6'd26, C_SY = 6'd27, C_AI = 6'd28,
      C_AL = 6'd29, C_CJ = 6'd30, C_EB = 6'd31, C_EM = 6'd32, C_H2 = 6'd33, C_H3 = 6'd34,
      C_HL = 6'd35, C_ID = 6'd36, C_JL = 6'd37, C_JV = 6'd38, C_JT = 6'd39, C_RI = 6'd40,
      C_SA = 6'd41, C_XX = 6'd42;

   localparam logic [1:0] K_PROHIBITED = 2'd0, K_OPTIONAL = 2'd1, K_MANDATORY = 2'd2;

   typedef struct packed {
      logic [5:0] prior_raw;
      logic [5:0] prior_res;
      logic [5:0] second_res;
      logic       zw_sp;
      logic       open_sp;
      logic       quote_sp;
      logic       close_sp;
      logic       b2_sp;
      logic       ri_odd;
      logic       have_prior;
   } ctx_type;

   localparam ctx_type CTX_CLEAR = '0;
endpackage

>>> rtl/lbc_if.sv
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
interface lbc_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] line_class;
   logic       start_of_text;
   logic       end_of_text;
   modport source (output valid, line_class, start_of_text, end_of_text, input ready);
   modport sink (input valid, line_class, start_of_text, end_of_text, output ready);
endinterface

interface lbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] break_kind;
   modport source (output valid, break_kind, input ready);
   modport sink (input valid, break_kind, output ready);
endinterface

>>> rtl/lbc_judge.sv
// Combinational break decision and context update for one codepoint class.
// Depends on lbc_pkg.
module lbc_judge import lbc_pkg::*; (
   input  logic [5:0] line_class,
   input  logic       start_of_text,
   input  logic       end_of_text,
   input  ctx_type    ctx,
   output logic [1:0] break_kind,
   output ctx_type    ctx_next
);
   ctx_type    c;
   logic [5:0] b;
   logic [5:0] bm;
   logic [5:0] a;
   logic [5:0] ar;
   logic [5:0] res;
   logic [1:0] k;
   logic       sp;
   logic       b_mark;

   always_comb begin
      c = start_of_text ? CTX_CLEAR : ctx;
      if (line_class > C_XX || line_class inside {C_AI, C_SG, C_XX, C_SA}) b = C_AL;
      else if (line_class == C_CJ) b = C_NS;
      else b = line_class;
      a = c.prior_res;
      ar = c.prior_raw;
      b_mark = b inside {C_CM, C_ZWJ};
      bm = b;
      if (b_mark && a inside {C_BK, C_CR, C_LF, C_NL, C_SP, C_ZW}) bm = C_AL;

      if (ar == C_CR) k = (b == C_LF) ? K_PROHIBITED : K_MANDATORY;
      else if (ar inside {C_LF, C_NL, C_BK}) k = K_MANDATORY;
      else if (b inside {C_BK, C_CR, C_LF, C_NL, C_SP, C_ZW}) k = K_PROHIBITED;
      else if (c.zw_sp) k = K_OPTIONAL;
      else if (ar == C_ZWJ && b inside {C_ID, C_EB, C_EM}) k = K_PROHIBITED;
      else if (b_mark && bm != C_AL) k = K_PROHIBITED;
      else if (a == C_WJ || bm == C_WJ || a == C_GL) k = K_PROHIBITED;
      else if (bm == C_GL && !(a inside {C_SP, C_BA, C_HY})) k = K_PROHIBITED;
      else if (bm inside {C_CL, C_CP, C_EX, C_IS, C_SY}) k = K_PROHIBITED;
      else if (c.open_sp) k = K_PROHIBITED;
      else if (bm == C_OP && c.quote_sp) k = K_PROHIBITED;
      else if (bm == C_NS && c.close_sp) k = K_PROHIBITED;
      else if (bm == C_B2 && c.b2_sp) k = K_PROHIBITED;
      else if (a == C_SP) k = K_OPTIONAL;
      else if (a == C_QU || bm == C_QU) k = K_PROHIBITED;
      else if (a == C_CB || bm == C_CB) k = K_OPTIONAL;
      else if (a == C_BB || bm inside {C_BA, C_HY, C_NS}) k = K_PROHIBITED;
      else if (a inside {C_HY, C_BA} && c.second_res == C_HL) k = K_PROHIBITED;
      else if (a == C_SY && bm == C_HL) k = K_PROHIBITED;
      else if (bm == C_IN && a inside {C_AL, C_HL, C_ID, C_EB, C_EM, C_EX, C_IN, C_NU})
         k = K_PROHIBITED;
      else if (a inside {C_AL, C_HL} && bm == C_NU) k = K_PROHIBITED;
      else if (a == C_NU && bm inside {C_AL, C_HL}) k = K_PROHIBITED;
      else if (a == C_PR && bm inside {C_ID, C_EB, C_EM}) k = K_PROHIBITED;
      else if (a inside {C_ID, C_EB, C_EM} && bm == C_PO) k = K_PROHIBITED;
      else if (a inside {C_PR, C_PO} && bm inside {C_AL, C_HL}) k = K_PROHIBITED;
      else if (a inside {C_AL, C_HL} && bm inside {C_PR, C_PO}) k = K_PROHIBITED;
      else if (a inside {C_CL, C_CP, C_NU} && bm inside {C_PO, C_PR}) k = K_PROHIBITED;
      else if (a inside {C_PO, C_PR} && bm inside {C_OP, C_NU}) k = K_PROHIBITED;
      else if (a inside {C_HY, C_IS, C_NU, C_SY} && bm == C_NU) k = K_PROHIBITED;
      else if (a == C_JL && bm inside {C_JL, C_JV, C_H2, C_H3}) k = K_PROHIBITED;
      else if (a inside {C_JV, C_H2} && bm inside {C_JV, C_JT}) k = K_PROHIBITED;
      else if (a inside {C_JT, C_H3} && bm == C_JT) k = K_PROHIBITED;
      else if (a inside {C_JL, C_JV, C_JT, C_H2, C_H3} && bm inside {C_IN, C_PO})
         k = K_PROHIBITED;
      else if (a == C_PR && bm inside {C_JL, C_JV, C_JT, C_H2, C_H3}) k = K_PROHIBITED;
      else if (a inside {C_AL, C_HL, C_IS} && bm inside {C_AL, C_HL}) k = K_PROHIBITED;
      else if (a inside {C_AL, C_HL, C_NU} && bm == C_OP) k = K_PROHIBITED;
      else if (a == C_CP && bm inside {C_AL, C_HL, C_NU}) k = K_PROHIBITED;
      else if (a == C_RI && bm == C_RI && c.ri_odd) k = K_PROHIBITED;
      else if (a == C_EB && bm == C_EM) k = K_PROHIBITED;
      else k = K_OPTIONAL;

      if (!b_mark) res = b;
      else if (!c.have_prior || a inside {C_BK, C_CR, C_LF, C_NL, C_SP, C_ZW}) res = C_AL;
      else res = a;

      sp = (b == C_SP);
      ctx_next.zw_sp = (b == C_ZW) || (sp && c.zw_sp);
      ctx_next.open_sp = (res == C_OP) || (sp && c.open_sp);
      ctx_next.quote_sp = (res == C_QU) || (sp && c.quote_sp);
      ctx_next.close_sp = (res == C_CL || res == C_CP) || (sp && c.close_sp);
      ctx_next.b2_sp = (res == C_B2) || (sp && c.b2_sp);
      ctx_next.ri_odd = (res != C_RI) ? 1'b0 : (b_mark ? c.ri_odd : !c.ri_odd);
      ctx_next.second_res = c.have_prior ? a : C_BK;
      ctx_next.prior_raw = b;
      ctx_next.prior_res = res;
      ctx_next.have_prior = 1'b1;

      if (end_of_text) begin
         break_kind = c.have_prior ? K_MANDATORY : K_PROHIBITED;
         ctx_next = CTX_CLEAR;
      end else begin
         break_kind = c.have_prior ? k : K_PROHIBITED;
      end
   end
endmodule

>>> rtl/line_break_classifier_unit.sv
// Streaming UAX #14 line-break classifier: one codepoint class per cycle in,
// one break kind (0 prohibited, 1 optional, 2 mandatory) out per request, in order.
// Each request passes through a single registered decision step; one
// request is accepted every cycle while the response register is empty or being
// drained, so sustained rate is one per clock; the response is registered.
// Running context lives in one register updated per accepted request.
module line_break_classifier_unit import lbc_pkg::*; (
   input logic      clock,
   input logic      reset,
   lbc_req_if.sink   req,
   lbc_rsp_if.source rsp
);
   ctx_type    ctx_ff, ctx_in;
   logic [1:0] kind_ff, kind_in;
   logic       valid_ff;
   logic       req_fire;

   assign req.ready = !valid_ff || rsp.ready;
   assign req_fire = req.valid && req.ready;
   assign rsp.valid = valid_ff;
   assign rsp.break_kind = kind_ff;

   lbc_judge u_judge (
      .line_class(req.line_class),
      .start_of_text(req.start_of_text),
      .end_of_text(req.end_of_text),
      .ctx(ctx_ff),
      .break_kind(kind_in),
      .ctx_next(ctx_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= CTX_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         if (req_fire) ctx_ff <= ctx_in;
         if (req.ready) valid_ff <= req.valid;
      end
      if (req_fire) kind_ff <= kind_in;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp.ready |=> valid_ff && $stable(kind_ff))
      else $error("response lost under stall");
   a_end: assert property (@(posedge clock) disable iff (reset)
      req_fire && req.end_of_text |=> !ctx_ff.have_prior)
      else $error("context kept after end marker");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> kind_ff != 2'd3)
      else $error("bad break kind");
endmodule

>>> dv/lbc_tb_if.sv
`timescale 1ns / 1ps
// Request item type for the testbench stimulus queue.
// The channel interfaces come from rtl/lbc_if.sv; no other dependencies.
package lbc_tb_pkg;
   typedef struct packed {
      logic [5:0] line_class;
      logic       start_of_text;
      logic       end_of_text;
   } req_item_type;
endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for line_break_classifier_unit: drives class requests,
// predicts break kinds with a local rule engine and checks responses in order.
// Depends on lbc_pkg, lbc_tb_pkg and the lbc_req_if / lbc_rsp_if interfaces.
module tb_top;
   import lbc_pkg::*;
   import lbc_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbc_req_if req ();
   lbc_rsp_if rsp ();

   line_break_classifier_unit u_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   req_item_type pending_reqs[$];
   logic [1:0]   expected_kinds[$];
   int unsigned  error_count = 0;
   bit           stim_done = 1'b0;
   bit           hold_sender = 1'b0;
   bit           req_taken = 1'b0;
   int           burst_left = 0;
   int           gap_left = 0;
   ctx_type      ctx = CTX_CLEAR;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit in_set(logic [5:0] c, logic [63:0] s);
      return s[c];
   endfunction

   function automatic logic [63:0] bits(logic [5:0] c);
      return 64'd1 << c;
   endfunction

   function automatic logic [5:0] fold_class(logic [5:0] c);
      if (c > C_XX || c == C_AI || c == C_SG || c == C_XX || c == C_SA) return C_AL;
      if (c == C_CJ) return C_NS;
      return c;
   endfunction

   function automatic logic [1:0] rule_kind(ctx_type s, logic [5:0] b_in);
      logic [63:0] hard, nobase, marks, letters, idlike, hangul;
      logic [5:0] ar, a, b;
      hard = bits(C_BK) | bits(C_CR) | bits(C_LF) | bits(C_NL);
      nobase = hard | bits(C_SP) | bits(C_ZW);
      marks = bits(C_CM) | bits(C_ZWJ);
      letters = bits(C_AL) | bits(C_HL);
      idlike = bits(C_ID) | bits(C_EB) | bits(C_EM);
      hangul = bits(C_JL) | bits(C_JV) | bits(C_JT) | bits(C_H2) | bits(C_H3);
      ar = s.prior_raw;
      a = s.prior_res;
      b = b_in;
      if (ar == C_CR) return (b == C_LF) ? K_PROHIBITED : K_MANDATORY;
      if (in_set(ar, bits(C_LF) | bits(C_NL) | bits(C_BK))) return K_MANDATORY;
      if (in_set(b, nobase)) return K_PROHIBITED;
      if (s.zw_sp) return K_OPTIONAL;
      if (ar == C_ZWJ && in_set(b, idlike)) return K_PROHIBITED;
      if (in_set(b, marks)) begin
         if (in_set(a, nobase)) b = C_AL;
         else return K_PROHIBITED;
      end
      if (a == C_WJ || b == C_WJ || a == C_GL) return K_PROHIBITED;
      if (b == C_GL && !in_set(a, bits(C_SP) | bits(C_BA) | bits(C_HY))) return K_PROHIBITED;
      if (in_set(b, bits(C_CL) | bits(C_CP) | bits(C_EX) | bits(C_IS) | bits(C_SY)))
         return K_PROHIBITED;
      if (s.open_sp) return K_PROHIBITED;
      if (b == C_OP && s.quote_sp) return K_PROHIBITED;
      if (b == C_NS && s.close_sp) return K_PROHIBITED;
      if (b == C_B2 && s.b2_sp) return K_PROHIBITED;
      if (a == C_SP) return K_OPTIONAL;
      if (a == C_QU || b == C_QU) return K_PROHIBITED;
      if (a == C_CB || b == C_CB) return K_OPTIONAL;
      if (a == C_BB || in_set(b, bits(C_BA) | bits(C_HY) | bits(C_NS))) return K_PROHIBITED;
      if (in_set(a, bits(C_HY) | bits(C_BA)) && s.second_res == C_HL) return K_PROHIBITED;
      if (a == C_SY && b == C_HL) return K_PROHIBITED;
      if (b == C_IN && in_set(a, letters | idlike | bits(C_EX) | bits(C_IN) | bits(C_NU)))
         return K_PROHIBITED;
      if (in_set(a, letters) && b == C_NU) return K_PROHIBITED;
      if (a == C_NU && in_set(b, letters)) return K_PROHIBITED;
      if (a == C_PR && in_set(b, idlike)) return K_PROHIBITED;
      if (in_set(a, idlike) && b == C_PO) return K_PROHIBITED;
      if (in_set(a, bits(C_PR) | bits(C_PO)) && in_set(b, letters)) return K_PROHIBITED;
      if (in_set(a, letters) && in_set(b, bits(C_PR) | bits(C_PO))) return K_PROHIBITED;
      if (in_set(a, bits(C_CL) | bits(C_CP) | bits(C_NU)) && in_set(b, bits(C_PO) | bits(C_PR)))
         return K_PROHIBITED;
      if (in_set(a, bits(C_PO) | bits(C_PR)) && in_set(b, bits(C_OP) | bits(C_NU)))
         return K_PROHIBITED;
      if (in_set(a, bits(C_HY) | bits(C_IS) | bits(C_NU) | bits(C_SY)) && b == C_NU)
         return K_PROHIBITED;
      if (a == C_JL && in_set(b, bits(C_JL) | bits(C_JV) | bits(C_H2) | bits(C_H3)))
         return K_PROHIBITED;
      if (in_set(a, bits(C_JV) | bits(C_H2)) && in_set(b, bits(C_JV) | bits(C_JT)))
         return K_PROHIBITED;
      if (in_set(a, bits(C_JT) | bits(C_H3)) && b == C_JT) return K_PROHIBITED;
      if (in_set(a, hangul) && in_set(b, bits(C_IN) | bits(C_PO))) return K_PROHIBITED;
      if (a == C_PR && in_set(b, hangul)) return K_PROHIBITED;
      if (in_set(a, letters | bits(C_IS)) && in_set(b, letters)) return K_PROHIBITED;
      if (in_set(a, letters | bits(C_NU)) && b == C_OP) return K_PROHIBITED;
      if (a == C_CP && in_set(b, letters | bits(C_NU))) return K_PROHIBITED;
      if (a == C_RI && b == C_RI && s.ri_odd) return K_PROHIBITED;
      if (a == C_EB && b == C_EM) return K_PROHIBITED;
      return K_OPTIONAL;
   endfunction

   // advance the running context and return the expected break kind
   function automatic logic [1:0] predict_break(req_item_type it);
      logic [5:0] b, res;
      logic [1:0] kind;
      logic [63:0] nobase;
      bit sp;
      nobase = bits(C_BK) | bits(C_CR) | bits(C_LF) | bits(C_NL) | bits(C_SP) | bits(C_ZW);
      b = fold_class(it.line_class);
      if (it.start_of_text) ctx = CTX_CLEAR;
      if (it.end_of_text) begin
         kind = ctx.have_prior ? K_MANDATORY : K_PROHIBITED;
         ctx = CTX_CLEAR;
         return kind;
      end
      kind = ctx.have_prior ? rule_kind(ctx, b) : K_PROHIBITED;
      if (b != C_CM && b != C_ZWJ) res = b;
      else if (!ctx.have_prior || in_set(ctx.prior_res, nobase)) res = C_AL;
      else res = ctx.prior_res;
      sp = (b == C_SP);
      ctx.zw_sp = (b == C_ZW) || (sp && ctx.zw_sp);
      ctx.open_sp = (res == C_OP) || (sp && ctx.open_sp);
      ctx.quote_sp = (res == C_QU) || (sp && ctx.quote_sp);
      ctx.close_sp = (res == C_CL || res == C_CP) || (sp && ctx.close_sp);
      ctx.b2_sp = (res == C_B2) || (sp && ctx.b2_sp);
      if (res != C_RI) ctx.ri_odd = 1'b0;
      else if (b != C_CM && b != C_ZWJ) ctx.ri_odd = ~ctx.ri_odd;
      ctx.second_res = ctx.have_prior ? ctx.prior_res : C_BK;
      ctx.prior_raw = b;
      ctx.prior_res = res;
      ctx.have_prior = 1'b1;
      return kind;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic push_req(logic [5:0] c, bit s, bit e);
      req_item_type it;
      it.line_class = c;
      it.start_of_text = s;
      it.end_of_text = e;
      pending_reqs.push_back(it);
   endtask

   function automatic logic [5:0] text_class();
      int r;
      logic [5:0] pool[16];
      pool = '{C_AL, C_SP, C_CM, C_ZWJ, C_OP, C_CL, C_QU, C_NU, C_HL, C_HY,
               C_RI, C_B2, C_ID, C_NS, C_PR, C_EB};
      r = $urandom_range(0, 9);
      if (r < 6) return pool[$urandom_range(0, 15)];
      return 6'($urandom_range(0, 63));
   endfunction

   // driver: bursts with random gaps, requests change on falling edge
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.line_class <= '0;
         req.start_of_text <= 1'b0;
         req.end_of_text <= 1'b0;
      end else if (!(req.valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req.valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !hold_sender) begin
            req_item_type it;
            it = pending_reqs.pop_front();
            req.valid <= 1'b1;
            req.line_class <= it.line_class;
            req.start_of_text <= it.start_of_text;
            req.end_of_text <= it.end_of_text;
            if (burst_left <= 0) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 3) != 0) || ($realtime < 300.0);
   end

   // monitor: predict on accepted request, check on accepted response
   always @(posedge clock) begin
      req_taken = !reset && req.valid && req.ready;
      if (!reset) begin
         if (req.valid && req.ready) begin
            req_item_type it;
            it.line_class = req.line_class;
            it.start_of_text = req.start_of_text;
            it.end_of_text = req.end_of_text;
            expected_kinds.push_back(predict_break(it));
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_kinds.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               logic [1:0] want;
               want = expected_kinds.pop_front();
               if (rsp.break_kind !== want)
                  report_mismatch($sformatf("break_kind got %0d want %0d",
                                            rsp.break_kind, want));
            end
         end
      end
   end

   initial begin
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: first item, CR LF, marks at start, ZW SP, OP SP, RI pairs, ends
      push_req(C_CM, 1'b1, 1'b0);
      push_req(C_CR, 1'b0, 1'b0);
      push_req(C_LF, 1'b0, 1'b0);
      push_req(C_AL, 1'b0, 1'b0);
      push_req(C_ZW, 1'b0, 1'b0);
      push_req(C_SP, 1'b0, 1'b0);
      push_req(C_ID, 1'b0, 1'b0);
      push_req(C_OP, 1'b0, 1'b0);
      push_req(C_SP, 1'b0, 1'b0);
      push_req(C_AL, 1'b0, 1'b0);
      push_req(C_RI, 1'b0, 1'b0);
      push_req(C_RI, 1'b0, 1'b0);
      push_req(C_RI, 1'b0, 1'b0);
      push_req(C_HL, 1'b0, 1'b0);
      push_req(C_HY, 1'b0, 1'b0);
      push_req(C_AL, 1'b0, 1'b0);
      push_req(6'd63, 1'b0, 1'b0);
      push_req(C_B2, 1'b0, 1'b0);
      push_req(C_SP, 1'b0, 1'b0);
      push_req(C_B2, 1'b0, 1'b0);
      push_req(6'h2a, 1'b0, 1'b1);
      push_req(6'h15, 1'b0, 1'b1);
      push_req(C_AL, 1'b1, 1'b1);
      push_req(C_ZWJ, 1'b0, 1'b0);
      push_req(C_EB, 1'b1, 1'b0);
      push_req(C_EM, 1'b0, 1'b0);
      // random texts, mostly well formed with noise
      n = 0;
      while (n < 400) begin
         int len;
         len = $urandom_range(1, 25);
         push_req(text_class(), 1'($urandom_range(0, 1)), 1'b0);
         n++;
         for (int k = 1; k < len; k++) begin
            push_req(text_class(), $urandom_range(0, 30) == 0, $urandom_range(0, 40) == 0);
            n++;
         end
         if ($urandom_range(0, 2) != 0) begin
            push_req(6'($urandom_range(0, 63)), $urandom_range(0, 4) == 0, 1'b1);
            n++;
         end
         if (n > 200 && n < 230) begin
            wait (pending_reqs.size() == 0);
            hold_sender = 1'b1;
            wait (expected_kinds.size() == 0 && !req.valid);
            repeat (3) @(posedge clock);
            hold_sender = 1'b0;
         end
      end
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req.valid && expected_kinds.size() == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("line_break_classifier_unit verification clean");
      end else begin
         $display("line_break_classifier_unit verification failed");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("line_break_classifier_unit verification failed");
      $finish;
   end
endmodule

>>> sim.f
rtl/lbc_pkg.sv
rtl/lbc_if.sv
rtl/lbc_judge.sv
rtl/line_break_classifier_unit.sv
dv/lbc_tb_if.sv
dv/tb_top.sv
